// ===== hdl/smrd_pkg.sv =====
// ----------------------------------------------------------------------------
// smrd_pkg
// Shared types and constants for the sign-magnitude restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smrd_pkg;

  // Item field widths, fixed by the channel definitions
  localparam int unsigned DIVIDEND_W  = 32;
  localparam int unsigned DIVISOR_W   = 16;
  localparam int unsigned QUOTIENT_W  = 16;
  localparam int unsigned REMAINDER_W = 16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/smrd_in_if.sv =====
// ----------------------------------------------------------------------------
// smrd_in_if
// Operand channel: valid/ready handshake with signed-magnitude operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smrd_in_if;
  import smrd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DIVIDEND_W-1:0] dividend_magnitude;
  logic                  dividend_sign;
  logic [DIVISOR_W-1:0]  divisor_magnitude;
  logic                  divisor_sign;

  modport source (
    output valid, dividend_magnitude, dividend_sign, divisor_magnitude, divisor_sign,
    input  ready
  );

  modport sink (
    input  valid, dividend_magnitude, dividend_sign, divisor_magnitude, divisor_sign,
    output ready
  );

endinterface

`default_nettype wire

// ===== hdl/smrd_out_if.sv =====
// ----------------------------------------------------------------------------
// smrd_out_if
// Result channel: valid/ready handshake with quotient, remainder and flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smrd_out_if;
  import smrd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [QUOTIENT_W-1:0]  quotient_magnitude;
  logic                   quotient_sign;
  logic [REMAINDER_W-1:0] remainder_magnitude;
  logic                   overflow_flag;

  modport source (
    output valid, quotient_magnitude, quotient_sign, remainder_magnitude, overflow_flag,
    input  ready
  );

  modport sink (
    input  valid, quotient_magnitude, quotient_sign, remainder_magnitude, overflow_flag,
    output ready
  );

endinterface

`default_nettype wire

// ===== hdl/sign_magnitude_restoring_divider.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_restoring_divider
// Restoring divider for sign-magnitude operands with overflow detection.
// ----------------------------------------------------------------------------
// Divides a 2*DIVISOR_WIDTH-bit dividend magnitude by a DIVISOR_WIDTH-bit
// divisor magnitude; bits above those widths are ignored. One item at a time:
// the block takes an item in ST_IDLE, runs the overflow check in ST_CHECK
// (upper dividend half not below the divisor, zero divisor included) and, if
// there is no overflow, DIVISOR_WIDTH shift-subtract steps in ST_STEP through
// a single (DIVISOR_WIDTH+1)-bit subtractor, then loads the result register in
// ST_DONE, which waits while an earlier result is held and out_ch.ready is
// low. It takes no new item until the result is loaded. The quotient sign is
// the XOR of the operand signs; on overflow both magnitudes read zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sign_magnitude_restoring_divider #(
  parameter int unsigned DIVISOR_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smrd_in_if.sink     in_ch,
  smrd_out_if.source  out_ch
);
  import smrd_pkg::*;

  localparam int unsigned N  = DIVISOR_WIDTH;
  localparam int unsigned CW = $clog2(N);

  // Sequencer and datapath registers
  state_t          state_r, state_nxt;
  logic [N-1:0]    a_r, a_nxt;          // partial remainder
  logic [N-1:0]    q_r, q_nxt;          // quotient bits / low dividend
  logic [N-1:0]    d_r, d_nxt;          // divisor
  logic            sign_r, sign_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [QUOTIENT_W-1:0]  out_quot_r, out_quot_nxt;
  logic [REMAINDER_W-1:0] out_rem_r, out_rem_nxt;
  logic                   out_sign_r, out_sign_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  // Operand fitting to the internal width
  logic [2*N+DIVIDEND_W-1:0] dvd_ext;
  logic [N+DIVISOR_W-1:0]    dvs_ext;
  logic [2*N-1:0]            dvd_fit;
  logic [N-1:0]              dvs_fit;
  logic [N+QUOTIENT_W-1:0]   quot_ext;
  logic [N+REMAINDER_W-1:0]  rem_ext;

  // Shared subtractor
  logic            e_bit;
  logic [N-1:0]    a_shift;
  logic [N:0]      sub_a;
  logic [N:0]      sub_diff;
  logic            borrow;

  assign dvd_ext  = {{(2*N){1'b0}}, in_ch.dividend_magnitude};
  assign dvs_ext  = {{N{1'b0}}, in_ch.divisor_magnitude};
  assign dvd_fit  = dvd_ext[2*N-1:0];
  assign dvs_fit  = dvs_ext[N-1:0];
  assign quot_ext = {{QUOTIENT_W{1'b0}}, q_r};
  assign rem_ext  = {{REMAINDER_W{1'b0}}, a_r};

  // Shift E,A,Q left by one; the check reuses the subtractor on plain A
  assign e_bit    = a_r[N-1];
  assign a_shift  = {a_r[N-2:0], q_r[N-1]};
  assign sub_a    = (state_r == ST_CHECK) ? {1'b0, a_r} : {e_bit, a_shift};
  assign sub_diff = sub_a - {1'b0, d_r};
  assign borrow   = sub_diff[N];

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid               = out_valid_r;
  assign out_ch.quotient_magnitude  = out_quot_r;
  assign out_ch.quotient_sign       = out_sign_r;
  assign out_ch.remainder_magnitude = out_rem_r;
  assign out_ch.overflow_flag       = out_ovf_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    q_r        <= q_nxt;
    d_r        <= d_nxt;
    sign_r     <= sign_nxt;
    ovf_r      <= ovf_nxt;
    out_quot_r <= out_quot_nxt;
    out_rem_r  <= out_rem_nxt;
    out_sign_r <= out_sign_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    q_nxt         = q_r;
    d_nxt         = d_r;
    sign_nxt      = sign_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_quot_nxt  = out_quot_r;
    out_rem_nxt   = out_rem_r;
    out_sign_nxt  = out_sign_r;
    out_ovf_nxt   = out_ovf_r;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt     = dvd_fit[2*N-1:N];
          q_nxt     = dvd_fit[N-1:0];
          d_nxt     = dvs_fit;
          sign_nxt  = in_ch.dividend_sign ^ in_ch.divisor_sign;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // overflow when divisor is zero or upper half not below it
        ovf_nxt = (d_r == '0) || !borrow;
        cnt_nxt = '0;
        if ((d_r == '0) || !borrow) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        // keep difference on carry out or no borrow, else restore
        if (e_bit || !borrow) begin
          a_nxt = sub_diff[N-1:0];
          q_nxt = {q_r[N-2:0], 1'b1};
        end else begin
          a_nxt = a_shift;
          q_nxt = {q_r[N-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sign_nxt  = sign_r;
          out_ovf_nxt   = ovf_r;
          out_quot_nxt  = ovf_r ? '0 : quot_ext[QUOTIENT_W-1:0];
          out_rem_nxt   = ovf_r ? '0 : rem_ext[REMAINDER_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
